@@ design/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic trigger scheduler
// Holds the channel payloads, the stored trigger entry and the mode and
// result codes.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Request codes carried in the mode field of an input item.
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result codes carried in the kind field of a result item.
    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_ADD_OK  = 2'd1;
    localparam logic [1:0] KIND_ADD_REJ = 2'd2;

    // At most this many triggers fire on one tick.
    localparam int MAX_RESULTS = 16;
    localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

    // Input item.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  trigger_id;
        logic [15:0] period_ms;
        logic        repeat_req;
        logic        allow_drift;
    } pts_in_t;

    // Result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  event_id;
        logic [15:0] event_period;
        logic        last;
    } pts_out_t;

    // Configuration write.
    typedef struct packed {
        logic [15:0] ticks_per_ms;
    } pts_cfg_t;

    // One trigger as held in the table memory.
    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] period;
        logic        drift;
        logic        repeat_en;
        logic [31:0] expiry;
        logic [31:0] order;
    } pts_entry_t;

endpackage

@@ design/pts_chan_if.sv @@
// ----------------------------------------------------------------------------
// pts_chan_if: valid/ready channel
// Carries one payload item per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface pts_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/pts_ram.sv @@
// ----------------------------------------------------------------------------
// pts_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ design/periodic_trigger_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_trigger_scheduler: table of periodic and one-shot triggers
// Adds and removes triggers and, on each tick, fires up to MAX_RESULTS expired ones,
// earliest expiry first, re-arming the repeating ones.
// ----------------------------------------------------------------------------
//
//  Channel | Role   | Payload    | Meaning
//  --------+--------+------------+--------------------------------------------
//  cmd     | sink   | pts_in_t   | tick, add trigger or remove triggers by id
//  evt     | source | pts_out_t  | fired trigger, add accepted or rejected
//  cfg     | sink   | pts_cfg_t  | ticks per millisecond, always ready
//
//  One item is taken at a time; cmd is ready only while the sequencer idles.
//  An add searches the valid bits for the lowest free slot, computes the
//  expiry and writes the entry. A remove makes one pass over the table. A tick
//  makes one selection pass per fired or dropped trigger plus one, and fires
//  or re-arms each trigger it picks. Each pass reads the table through the
//  single memory read port, one entry per cycle. Reset empties the table
//  through per-entry valid flip-flops, so no clearing pass is needed;
//  ticks_per_ms resets to 1. A stalled evt holds the sequencer at its next
//  result until the waiting result is taken.
// ----------------------------------------------------------------------------
module periodic_trigger_scheduler #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    pts_chan_if.sink   cmd,
    pts_chan_if.source evt,
    pts_chan_if.sink   cfg
);
    import pts_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);
    localparam logic [FIRED_W-1:0] FIRED_CAP = FIRED_W'(MAX_RESULTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_FIND,
        S_ADD_MUL,
        S_ADD_WR,
        S_ADD_REJ,
        S_REM_SCAN,
        S_TICK_SCAN,
        S_TICK_PICK,
        S_TICK_FIRE,
        S_TICK_REARM,
        S_TICK_END
    } state_t;

    // Registers and their next values.
    state_t                   state_reg,    state_next;
    logic [31:0]              now_reg,      now_next;
    logic [31:0]              order_reg,    order_next;
    logic [15:0]              tpm_reg,      tpm_next;
    logic [TABLE_DEPTH-1:0]   valid_reg,    valid_next;
    logic [TABLE_DEPTH-1:0]   pend_reg,     pend_next;
    logic [CNT_W-1:0]         cnt_reg,      cnt_next;
    logic                     dvld_reg,     dvld_next;
    logic [IDX_W-1:0]         didx_reg,     didx_next;
    logic                     first_reg,    first_next;
    logic                     best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [31:0]              best_age_reg, best_age_next;
    pts_entry_t               best_reg,     best_next;
    logic [FIRED_W-1:0]       fired_reg,    fired_next;
    logic                     held_vld_reg, held_vld_next;
    logic [7:0]               held_id_reg,  held_id_next;
    logic [15:0]              held_per_reg, held_per_next;
    logic [31:0]              prod_reg,     prod_next;
    pts_in_t                  cmd_reg,      cmd_next;
    logic                     out_vld_reg,  out_vld_next;
    pts_out_t                 out_reg,      out_next;

    // Memory port signals.
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    pts_entry_t               ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    pts_entry_t               rd_ent;

    // Shared datapath signals.
    logic                     out_free;
    logic [IDX_W-1:0]         cnt_idx;
    logic [15:0]              mul_per;
    logic [31:0]              age;
    logic [31:0]              odiff;
    logic                     cand;
    logic                     better;
    logic [31:0]              rearm_base;

    // Trigger table memory.
    pts_ram #(
        .WIDTH ($bits(pts_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_ent)
    );

    // Channel outputs.
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign evt.valid = out_vld_reg;
    assign evt.data  = out_reg;
    assign out_free  = !out_vld_reg || evt.ready;

    // Scan address and read issue.
    assign cnt_idx     = cnt_reg[IDX_W-1:0];
    assign ram_rd_addr = cnt_idx;
    assign ram_rd_en   = ((state_reg == S_REM_SCAN) || (state_reg == S_TICK_SCAN))
                         && (cnt_reg < CNT_END);

    // Expiry age and firing order of the entry coming out of the memory.
    assign age    = now_reg - rd_ent.expiry;
    assign odiff  = rd_ent.order - best_reg.order;
    assign cand   = first_reg ? (valid_reg[didx_reg] && (age != 32'd0) && !age[31])
                              : pend_reg[didx_reg];
    assign better = !best_vld_reg || (age > best_age_reg)
                    || ((age == best_age_reg) && odiff[31]);

    // Shared multiplier operand and re-arm base time.
    assign mul_per    = (state_reg == S_TICK_FIRE) ? best_reg.period : cmd_reg.period_ms;
    assign rearm_base = best_reg.drift ? now_reg : best_reg.expiry;

    // Sequencer next-state and datapath logic.
    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        order_next    = order_reg;
        tpm_next      = tpm_reg;
        valid_next    = valid_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        dvld_next     = ram_rd_en;
        didx_next     = cnt_idx;
        first_next    = first_reg;
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        best_next     = best_reg;
        fired_next    = fired_reg;
        held_vld_next = held_vld_reg;
        held_id_next  = held_id_reg;
        held_per_next = held_per_reg;
        prod_next     = prod_reg;
        cmd_next      = cmd_reg;
        out_vld_next  = out_vld_reg && !evt.ready;
        out_next      = out_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = didx_reg;
        ram_wr_data   = rd_ent;

        // Configuration writes are taken in any state.
        if (cfg.valid)
        begin
            tpm_next = cfg.data.ticks_per_ms;
        end

        // Scan counter advances one entry per issued read.
        if (ram_rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next      = cmd.data;
                    cnt_next      = '0;
                    best_vld_next = 1'b0;
                    unique case (cmd.data.mode)
                        MODE_TICK:
                        begin
                            now_next      = now_reg + 32'd1;
                            first_next    = 1'b1;
                            fired_next    = '0;
                            held_vld_next = 1'b0;
                            state_next    = S_TICK_SCAN;
                        end
                        MODE_ADD:
                        begin
                            state_next = (cmd.data.trigger_id == 8'd0) ? S_ADD_REJ
                                                                       : S_ADD_FIND;
                        end
                        MODE_REMOVE:
                        begin
                            state_next = S_REM_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Search the valid bits for the lowest free slot.
            S_ADD_FIND:
            begin
                if (!valid_reg[cnt_idx])
                begin
                    state_next = S_ADD_MUL;
                end
                else if (cnt_idx == LAST_IDX)
                begin
                    state_next = S_ADD_REJ;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_ADD_MUL:
            begin
                prod_next  = 32'(tpm_reg) * 32'(mul_per);
                state_next = S_ADD_WR;
            end

            // Store the new trigger and report it.
            S_ADD_WR:
            begin
                if (out_free)
                begin
                    ram_wr_en             = 1'b1;
                    ram_wr_addr           = cnt_idx;
                    ram_wr_data.ident     = cmd_reg.trigger_id;
                    ram_wr_data.period    = cmd_reg.period_ms;
                    ram_wr_data.drift     = cmd_reg.allow_drift;
                    ram_wr_data.repeat_en = cmd_reg.repeat_req;
                    ram_wr_data.expiry    = now_reg + prod_reg;
                    ram_wr_data.order     = order_reg;
                    valid_next[cnt_idx]   = 1'b1;
                    order_next            = order_reg + 32'd1;
                    out_vld_next          = 1'b1;
                    out_next              = '{KIND_ADD_OK, cmd_reg.trigger_id,
                                              cmd_reg.period_ms, 1'b1};
                    state_next            = S_IDLE;
                end
            end

            S_ADD_REJ:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_next     = '{KIND_ADD_REJ, cmd_reg.trigger_id,
                                     cmd_reg.period_ms, 1'b1};
                    state_next   = S_IDLE;
                end
            end

            // Zero the period of every valid entry with the requested id.
            S_REM_SCAN:
            begin
                if (dvld_reg)
                begin
                    if (valid_reg[didx_reg] && (rd_ent.ident == cmd_reg.trigger_id))
                    begin
                        ram_wr_en          = 1'b1;
                        ram_wr_data.period = 16'd0;
                    end
                    if (didx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // One pass over the table: mark due entries and pick the first to go.
            S_TICK_SCAN:
            begin
                if (dvld_reg)
                begin
                    if (first_reg)
                    begin
                        pend_next[didx_reg] = cand;
                    end
                    if (cand && better)
                    begin
                        best_vld_next = 1'b1;
                        best_idx_next = didx_reg;
                        best_age_next = age;
                        best_next     = rd_ent;
                    end
                    if (didx_reg == LAST_IDX)
                    begin
                        state_next = S_TICK_PICK;
                    end
                end
            end

            S_TICK_PICK:
            begin
                if (!best_vld_reg)
                begin
                    state_next = S_TICK_END;
                end
                else if (best_reg.period == 16'd0)
                begin
                    // A removed trigger is dropped silently and does not count.
                    valid_next[best_idx_reg] = 1'b0;
                    pend_next[best_idx_reg]  = 1'b0;
                    cnt_next                 = '0;
                    best_vld_next            = 1'b0;
                    first_next               = 1'b0;
                    state_next               = S_TICK_SCAN;
                end
                else if (fired_reg == FIRED_CAP)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    state_next = S_TICK_FIRE;
                end
            end

            // Release the previous firing, now known not to be the last one.
            S_TICK_FIRE:
            begin
                if (!held_vld_reg || out_free)
                begin
                    if (held_vld_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_next     = '{KIND_FIRED, held_id_reg, held_per_reg, 1'b0};
                    end
                    held_vld_next           = 1'b1;
                    held_id_next            = best_reg.ident;
                    held_per_next           = best_reg.period;
                    fired_next              = fired_reg + FIRED_W'(1);
                    pend_next[best_idx_reg] = 1'b0;
                    prod_next               = 32'(tpm_reg) * 32'(mul_per);
                    if (best_reg.repeat_en)
                    begin
                        state_next = S_TICK_REARM;
                    end
                    else
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        cnt_next                 = '0;
                        best_vld_next            = 1'b0;
                        first_next               = 1'b0;
                        state_next               = S_TICK_SCAN;
                    end
                end
            end

            // Write back a repeating trigger with its next expiry.
            S_TICK_REARM:
            begin
                ram_wr_en          = 1'b1;
                ram_wr_addr        = best_idx_reg;
                ram_wr_data        = best_reg;
                ram_wr_data.expiry = rearm_base + prod_reg;
                ram_wr_data.order  = order_reg;
                order_next         = order_reg + 32'd1;
                cnt_next           = '0;
                best_vld_next      = 1'b0;
                first_next         = 1'b0;
                state_next         = S_TICK_SCAN;
            end

            // Release the final firing of this tick with the last mark.
            S_TICK_END:
            begin
                if (!held_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_next      = '{KIND_FIRED, held_id_reg, held_per_reg, 1'b1};
                    held_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            order_reg    <= '0;
            tpm_reg      <= 16'd1;
            valid_reg    <= '0;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            dvld_reg     <= 1'b0;
            didx_reg     <= '0;
            first_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            best_idx_reg <= '0;
            best_age_reg <= '0;
            best_reg     <= '0;
            fired_reg    <= '0;
            held_vld_reg <= 1'b0;
            held_id_reg  <= '0;
            held_per_reg <= '0;
            prod_reg     <= '0;
            cmd_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            order_reg    <= order_next;
            tpm_reg      <= tpm_next;
            valid_reg    <= valid_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            dvld_reg     <= dvld_next;
            didx_reg     <= didx_next;
            first_reg    <= first_next;
            best_vld_reg <= best_vld_next;
            best_idx_reg <= best_idx_next;
            best_age_reg <= best_age_next;
            best_reg     <= best_next;
            fired_reg    <= fired_next;
            held_vld_reg <= held_vld_next;
            held_id_reg  <= held_id_next;
            held_per_reg <= held_per_next;
            prod_reg     <= prod_next;
            cmd_reg      <= cmd_next;
            out_vld_reg  <= out_vld_next;
            out_reg      <= out_next;
        end
    end
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the periodic trigger scheduler
// Sends ticks, adds and removes over the command channel. A behavioral copy
// of the trigger table predicts every result item, and each result is checked
// field by field in order. The run covers several ticks-per-ms settings, from
// zero up to the 16-bit maximum, under several sender and receiver idle
// patterns.
// ----------------------------------------------------------------------------
module tb;
    import pts_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int SEG_COUNT      = 8;
    localparam int SEG_ITEMS      = 49;
    localparam int SETTLE_CYCLES  = 700;
    localparam int WATCHDOG_LIMIT = 20000;

    // The fourth mode code, which the block ignores.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One command item, optionally with its single result typed in.
    typedef struct packed {
        pts_in_t  item;
        logic     typed;
        pts_out_t want;
    } cmd_rec_t;

    // One row of the directed table: a command repeated reps times.
    typedef struct packed {
        logic [4:0] reps;
        cmd_rec_t   rec;
    } dir_row_t;

    localparam pts_out_t NO_RESULT = '0;
    localparam int       DIR_LEN   = 12;

    // Directed sequence: reset state, field extremes, id zero, period zero,
    // remove, ignored mode, filling the table and a full-table reject.
    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        '{5'd1,  '{'{MODE_TICK,   8'd0,   16'd0,     1'b0, 1'b0}, 1'b0, NO_RESULT}},
        '{5'd1,  '{'{MODE_ADD,    8'd0,   16'd5,     1'b0, 1'b0}, 1'b1,
                   '{KIND_ADD_REJ, 8'd0,   16'd5,     1'b1}}},
        '{5'd1,  '{'{MODE_ADD,    8'd1,   16'd1,     1'b1, 1'b0}, 1'b1,
                   '{KIND_ADD_OK,  8'd1,   16'd1,     1'b1}}},
        '{5'd1,  '{'{MODE_ADD,    8'd255, 16'd65535, 1'b1, 1'b1}, 1'b1,
                   '{KIND_ADD_OK,  8'd255, 16'd65535, 1'b1}}},
        '{5'd1,  '{'{MODE_ADD,    8'd2,   16'd0,     1'b0, 1'b0}, 1'b1,
                   '{KIND_ADD_OK,  8'd2,   16'd0,     1'b1}}},
        '{5'd1,  '{'{MODE_ADD,    8'd3,   16'd2,     1'b0, 1'b1}, 1'b1,
                   '{KIND_ADD_OK,  8'd3,   16'd2,     1'b1}}},
        '{5'd1,  '{'{MODE_REMOVE, 8'd3,   16'd0,     1'b0, 1'b0}, 1'b0, NO_RESULT}},
        '{5'd1,  '{'{MODE_UNUSED, 8'd9,   16'd7,     1'b1, 1'b1}, 1'b0, NO_RESULT}},
        '{5'd3,  '{'{MODE_TICK,   8'd0,   16'd0,     1'b0, 1'b0}, 1'b0, NO_RESULT}},
        '{5'd14, '{'{MODE_ADD,    8'd100, 16'd1,     1'b0, 1'b0}, 1'b1,
                   '{KIND_ADD_OK,  8'd100, 16'd1,     1'b1}}},
        '{5'd1,  '{'{MODE_ADD,    8'd7,   16'd9,     1'b1, 1'b1}, 1'b1,
                   '{KIND_ADD_REJ, 8'd7,   16'd9,     1'b1}}},
        '{5'd2,  '{'{MODE_TICK,   8'd0,   16'd0,     1'b0, 1'b0}, 1'b0, NO_RESULT}}
    };

    // Ticks per ms and idle pattern of each random segment.
    localparam logic [15:0] SEG_TPM [SEG_COUNT] =
        '{16'd1, 16'd0, 16'd0, 16'd3, 16'd3, 16'd65535, 16'd65535, 16'd1};
    localparam int SEND_IDLE_PCT [4] = '{0, 63, 0, 13};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 63, 13};

    logic clk;
    logic rst_n;

    pts_chan_if #(.payload_t(pts_in_t))  cmd_ch ();
    pts_chan_if #(.payload_t(pts_out_t)) evt_ch ();
    pts_chan_if #(.payload_t(pts_cfg_t)) cfg_ch ();

    periodic_trigger_scheduler #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    // Behavioral copy of the trigger table.
    logic [15:0] tpm_m;
    logic [31:0] now_m;
    logic [31:0] order_m;
    bit          live_m [TABLE_DEPTH];
    pts_entry_t  slot_m [TABLE_DEPTH];

    pts_out_t expected_events [$];
    pts_out_t step_results [$];
    cmd_rec_t pending_cmds [$];
    cmd_rec_t cur_cmd;
    bit       cmd_in_flight;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       fail_count;
    int       quiet_cycles;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // An entry is due when its age lies in 1 .. 2^31-1, modulo 2^32.
    function automatic bit is_due(int i);
        logic [31:0] age;
        age = now_m - slot_m[i].expiry;
        return (age != 32'd0) && !age[31];
    endfunction

    // Oldest expiry fires first; ties go to the lower insertion order.
    function automatic bit fires_first(int a, int b);
        logic [31:0] age_a;
        logic [31:0] age_b;
        logic [31:0] gap;
        age_a = now_m - slot_m[a].expiry;
        age_b = now_m - slot_m[b].expiry;
        gap   = slot_m[a].order - slot_m[b].order;
        if (age_a != age_b)
            return age_a > age_b;
        return gap[31];
    endfunction

    // Applies one command to the table copy and lists the results it causes.
    function automatic void predict_command(input pts_in_t c, ref pts_out_t res [$]);
        int          slot;
        int          best;
        bit          pend [TABLE_DEPTH];
        logic [31:0] interval;
        pts_out_t    r;
        res.delete();
        case (c.mode)
            MODE_ADD:
            begin
                slot = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (!live_m[i] && slot < 0)
                        slot = i;
                r.event_id     = c.trigger_id;
                r.event_period = c.period_ms;
                r.last         = 1'b1;
                if (c.trigger_id == 8'd0 || slot < 0)
                begin
                    r.kind = KIND_ADD_REJ;
                end
                else
                begin
                    r.kind                 = KIND_ADD_OK;
                    live_m[slot]           = 1'b1;
                    slot_m[slot].ident     = c.trigger_id;
                    slot_m[slot].period    = c.period_ms;
                    slot_m[slot].repeat_en = c.repeat_req;
                    slot_m[slot].drift     = c.allow_drift;
                    slot_m[slot].expiry    = now_m + 32'(tpm_m) * 32'(c.period_ms);
                    slot_m[slot].order     = order_m;
                    order_m                = order_m + 32'd1;
                end
                res.push_back(r);
            end
            MODE_REMOVE:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (live_m[i] && slot_m[i].ident == c.trigger_id)
                        slot_m[i].period = 16'd0;
            end
            MODE_TICK:
            begin
                now_m = now_m + 32'd1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    pend[i] = live_m[i] && is_due(i);
                forever
                begin
                    best = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (pend[i] && (best < 0 || fires_first(i, best)))
                            best = i;
                    if (best < 0)
                        break;
                    // Removed entries leave silently and do not count toward the cap.
                    if (slot_m[best].period == 16'd0)
                    begin
                        pend[best]   = 1'b0;
                        live_m[best] = 1'b0;
                        continue;
                    end
                    if (res.size() >= MAX_RESULTS)
                        break;
                    pend[best]     = 1'b0;
                    r.kind         = KIND_FIRED;
                    r.event_id     = slot_m[best].ident;
                    r.event_period = slot_m[best].period;
                    r.last         = 1'b0;
                    res.push_back(r);
                    if (slot_m[best].repeat_en)
                    begin
                        interval = 32'(tpm_m) * 32'(slot_m[best].period);
                        if (slot_m[best].drift)
                            slot_m[best].expiry = now_m + interval;
                        else
                            slot_m[best].expiry = slot_m[best].expiry + interval;
                        slot_m[best].order = order_m;
                        order_m            = order_m + 32'd1;
                    end
                    else
                    begin
                        live_m[best] = 1'b0;
                    end
                end
                if (res.size() > 0)
                begin
                    r      = res[res.size() - 1];
                    r.last = 1'b1;
                    res[res.size() - 1] = r;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Random command, biased so that triggers come due often at this setting.
    function automatic pts_in_t random_command(input logic [15:0] tpm);
        pts_in_t c;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 52)
            c.mode = MODE_TICK;
        else if (r < 88)
            c.mode = MODE_ADD;
        else if (r < 97)
            c.mode = MODE_REMOVE;
        else
            c.mode = MODE_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 70)
            c.trigger_id = 8'($urandom_range(1, 12));
        else if (r < 80)
            c.trigger_id = 8'd0;
        else
            c.trigger_id = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        // At the largest setting, long periods wrap and come due at once.
        if (tpm == 16'hFFFF)
        begin
            if (r < 15)
                c.period_ms = 16'd0;
            else if (r < 85)
                c.period_ms = 16'($urandom_range(32769, 65535));
            else
                c.period_ms = 16'($urandom_range(0, 65535));
        end
        else if (r < 95)
        begin
            c.period_ms = 16'($urandom_range(0, 4));
        end
        else
        begin
            c.period_ms = 16'($urandom_range(0, 65535));
        end
        c.repeat_req  = 1'($urandom_range(0, 1));
        c.allow_drift = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Waits until every command is taken and answered, then lets the block settle.
    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_in_flight || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the ticks-per-ms register and updates the table copy on acceptance.
    task automatic write_ticks_per_ms(input logic [15:0] value);
        @(posedge clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.data.ticks_per_ms <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tpm_m = value;
    endtask

    // Command driver: predicts each accepted item and loads the next one.
    always @(posedge clk)
    begin : drive_commands
        bit hold;
        if (rst_n)
        begin
            hold = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_command(cur_cmd.item, step_results);
                if (cur_cmd.typed)
                    expected_events.push_back(cur_cmd.want);
                else
                    foreach (step_results[k])
                        expected_events.push_back(step_results[k]);
                hold          = 1'b0;
                cmd_in_flight = 1'b0;
            end
            if (!hold && pending_cmds.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_cmd       = pending_cmds.pop_front();
                hold          = 1'b1;
                cmd_in_flight = 1'b1;
                cmd_ch.data  <= cur_cmd.item;
            end
            cmd_ch.valid <= hold;
        end
    end

    // Result receiver with random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
            evt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: each result against the oldest expected one.
    always @(posedge clk)
    begin : check_events
        pts_out_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result: kind %0d id %0d period %0d last %0d",
                       evt_ch.data.kind, evt_ch.data.event_id,
                       evt_ch.data.event_period, evt_ch.data.last);
                fail_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_ch.data.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, evt_ch.data.kind);
                    fail_count++;
                end
                if (evt_ch.data.event_id !== want.event_id)
                begin
                    $error("event_id: expected %0d, actual %0d",
                           want.event_id, evt_ch.data.event_id);
                    fail_count++;
                end
                if (evt_ch.data.event_period !== want.event_period)
                begin
                    $error("event_period: expected %0d, actual %0d",
                           want.event_period, evt_ch.data.event_period);
                    fail_count++;
                end
                if (evt_ch.data.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, evt_ch.data.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin : run_test
        dir_row_t    row;
        cmd_rec_t    rec;
        logic [15:0] cur_tpm;
        int          n;

        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.data     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        evt_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        cmd_in_flight   = 1'b0;
        tpm_m           = 16'd1;
        now_m           = '0;
        order_m         = '0;
        foreach (live_m[i])
            live_m[i] = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, walked row by row.
        for (int k = 0; k < DIR_LEN; k++)
        begin
            row = DIR_ROWS[k];
            for (n = 0; n < row.reps; n++)
                pending_cmds.push_back(row.rec);
        end
        drain();

        // Random segments over several register settings and idle patterns.
        cur_tpm = 16'd1;
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            if (SEG_TPM[seg] != cur_tpm)
            begin
                write_ticks_per_ms(SEG_TPM[seg]);
                cur_tpm = SEG_TPM[seg];
            end
            send_idle_pct  = SEND_IDLE_PCT[seg % 4];
            recv_stall_pct = RECV_STALL_PCT[seg % 4];
            n = 0;
            while (n < SEG_ITEMS)
            begin
                rec.item  = random_command(cur_tpm);
                rec.typed = 1'b0;
                rec.want  = NO_RESULT;
                if (rec.item.mode != MODE_UNUSED)
                    n++;
                pending_cmds.push_back(rec);
            end
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ periodic_trigger_scheduler.f @@
design/pts_pkg.sv
design/pts_chan_if.sv
design/pts_ram.sv
design/periodic_trigger_scheduler.sv
verif/tb.sv
